// ===== hdl/tmlcg_pkg.sv =====
// shared types, register indexes and constants of the chirp generator
package tmlcg_pkg;

   localparam int CHANNELS      = 4;
   localparam int CHANNEL_BITS  = 2;
   localparam int COUNT_BITS    = 16;
   localparam int CH_COUNT_BITS = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CFG_BITS      = 32;
   localparam int SAMPLE_BITS   = 16;
   localparam int AMP_BITS      = 15;

   typedef logic [CHANNELS-1:0] chan_mask_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PERIOD_SAMPLES = 3'd0,
      CSR_PULSE_SAMPLES  = 3'd1,
      CSR_START_PHASE    = 3'd2,
      CSR_START_STEP     = 3'd3,
      CSR_STEP_INCREMENT = 3'd4,
      CSR_CHANNEL_COUNT  = 3'd5,
      CSR_CHANNEL_ENABLE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_RISE_POS = 2'd0,
      QUAD_FALL_POS = 2'd1,
      QUAD_RISE_NEG = 2'd2,
      QUAD_FALL_NEG = 2'd3
   } quad_type;

   localparam logic [COUNT_BITS-1:0]    PERIOD_RESET  = 16'd3072;
   localparam logic [COUNT_BITS-1:0]    PULSE_RESET   = 16'd2457;
   localparam logic [CFG_BITS-1:0]      PHASE_RESET   = 32'd0;
   localparam logic [CFG_BITS-1:0]      STEP_RESET    = 32'd0;
   localparam logic [CFG_BITS-1:0]      INCR_RESET    = 32'd0;
   localparam logic [CH_COUNT_BITS-1:0] COUNT_RESET   = 3'd4;
   localparam chan_mask_type            ENABLE_RESET  = 4'hF;

   // quarter-wave table generation, Q30 Horner series of sin(x)/x
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] AMP_MAX = 64'd32767;
   localparam logic [63:0] HORNER_DIVS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

endpackage

// ===== hdl/tdm_mimo_lfm_chirp_generator_unit.sv =====
// top level: time-division mimo lfm chirp generator, one sample per word
//
// req channel: one word per output tick, req_restart high restarts the frame
//   at position zero of the first enabled channel slot.
// rsp channel: i/q sample in q1.15, owning channel, chirp active flag,
//   position within the slot and end-of-frame marker.
// csr port: csr_write with csr_index/csr_data writes one register at the edge;
//   phase registers take effect at the next slot start. write only when idle.
// throughput: one word per cycle while rsp_stall is low; the slot/phase update is a single pass of
//   compare, increment and one phase add, followed by a registered dual read
//   of the quarter-wave rom.
// path: two registered stages from accept to rsp_valid (update stage, rom stage).
// with no channel enabled a word is accepted and gives no result.
// when rsp_stall holds a result the update stage still takes one more word;
//   req_stall rises only when both stages are full.
// reset (synchronous, active high) clears both stages, loads the register
//   defaults and starts at slot position zero of the first enabled channel.
module tdm_mimo_lfm_chirp_generator_unit
   import tmlcg_pkg::*;
#(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]   rsp_sample_i,
   output logic signed [SAMPLE_BITS-1:0]   rsp_sample_q,
   output logic [CHANNEL_BITS-1:0]         rsp_channel,
   output logic                            rsp_active,
   output logic [COUNT_BITS-1:0]           rsp_slot_position,
   output logic                            rsp_end_of_frame,
   input  logic                            csr_write,
   input  logic [CSR_IDX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_data
);

   localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
   localparam int FRAC_BITS = PHASE_BITS - 2;
   localparam int PROD_BITS = FRAC_BITS + IDX_BITS;

   typedef logic [AMP_BITS-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   typedef struct packed {
      logic [PHASE_BITS-1:0]   phase;
      logic [CHANNEL_BITS-1:0] chan;
      logic [COUNT_BITS-1:0]   pos;
      logic                    active;
      logic                    eof;
   } upd_word_type;

   typedef struct packed {
      logic [AMP_BITS-1:0]     amp_a;
      logic [AMP_BITS-1:0]     amp_b;
      quad_type                quad;
      logic [CHANNEL_BITS-1:0] chan;
      logic [COUNT_BITS-1:0]   pos;
      logic                    active;
      logic                    eof;
   } out_word_type;

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  s;
      logic [63:0]  r;
      logic [63:0]  v;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         x  = (64'(2 * k + 1) * PI_Q30) / 64'(4 * SINE_TABLE_DEPTH);
         x2 = (x * x) >> 30;
         s  = Q30_ONE;
         for (int n = 0; n < 6; n++) begin
            s = Q30_ONE - (((x2 * s) >> 30) / HORNER_DIVS[n]);
         end
         r = (x * s) >> 30;
         v = (r * AMP_MAX + (64'd1 << 29)) >> 30;
         rom[k] = (v > AMP_MAX) ? AMP_BITS'(AMP_MAX) : v[AMP_BITS-1:0];
      end
      return rom;
   endfunction

   function automatic logic [CHANNEL_BITS-1:0] first_enabled(input chan_mask_type mask);
      logic [CHANNEL_BITS-1:0] pick;
      logic                    found;
      pick  = '0;
      found = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (mask[c] && !found) begin
            pick  = CHANNEL_BITS'(c);
            found = 1'b1;
         end
      end
      return pick;
   endfunction

   function automatic logic [CHANNEL_BITS-1:0] last_enabled(input chan_mask_type mask);
      logic [CHANNEL_BITS-1:0] pick;
      pick = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (mask[c]) begin
            pick = CHANNEL_BITS'(c);
         end
      end
      return pick;
   endfunction

   function automatic logic [CHANNEL_BITS-1:0] next_enabled(
      input logic [CHANNEL_BITS-1:0] chan,
      input chan_mask_type           mask
   );
      logic [CHANNEL_BITS-1:0] pick;
      logic [CHANNEL_BITS-1:0] cand;
      logic                    found;
      pick  = chan;
      found = 1'b0;
      for (int i = 1; i <= CHANNELS; i++) begin
         cand = CHANNEL_BITS'((int'(chan) + i) % CHANNELS);
         if (mask[cand] && !found) begin
            pick  = cand;
            found = 1'b1;
         end
      end
      return pick;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // configuration
   logic [COUNT_BITS-1:0]    period_ff;
   logic [COUNT_BITS-1:0]    pulse_ff;
   logic [CFG_BITS-1:0]      start_phase_ff;
   logic [CFG_BITS-1:0]      start_step_ff;
   logic [CFG_BITS-1:0]      step_incr_ff;
   logic [CH_COUNT_BITS-1:0] chan_count_ff;
   chan_mask_type            chan_enable_ff;

   // slot state
   logic [COUNT_BITS-1:0]    pos_ff,   pos_in;
   logic [CHANNEL_BITS-1:0]  chan_ff,  chan_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic [PHASE_BITS-1:0]    step_ff,  step_in;

   // pipeline
   logic                     upd_valid_ff, upd_valid_in;
   upd_word_type             upd_ff,       upd_in;
   logic                     out_valid_ff, out_valid_in;
   out_word_type             out_ff;

   logic                     out_move;
   logic                     upd_move;
   logic                     req_take;
   logic                     state_load;

   chan_mask_type            mask_c;
   logic [COUNT_BITS-1:0]    period_c;
   logic [COUNT_BITS-1:0]    pulse_c;
   logic [CHANNEL_BITS-1:0]  first_c;
   logic                     reload_c;
   logic [CHANNEL_BITS-1:0]  chan_use;
   logic [COUNT_BITS-1:0]    pos_use;
   logic [PHASE_BITS-1:0]    phase_use;
   logic [PHASE_BITS-1:0]    step_use;
   logic [PHASE_BITS-1:0]    load_phase;
   logic [PHASE_BITS-1:0]    load_step;
   logic [PHASE_BITS-1:0]    load_incr;
   logic                     active_c;
   logic [COUNT_BITS-1:0]    pos_inc;
   logic                     slot_end;

   logic [FRAC_BITS-1:0]     frac_c;
   logic [PROD_BITS-1:0]     prod_c;
   logic [IDX_BITS-1:0]      idx_c;
   logic [IDX_BITS-1:0]      idx_rev_c;

   logic signed [SAMPLE_BITS-1:0] amp_a_s;
   logic signed [SAMPLE_BITS-1:0] amp_b_s;
   logic signed [SAMPLE_BITS-1:0] cos_c;
   logic signed [SAMPLE_BITS-1:0] sin_c;

   // handshake
   assign out_move  = !out_valid_ff || !rsp_stall;
   assign upd_move  = !upd_valid_ff || out_move;
   assign req_stall = !upd_move;
   assign req_take  = req_valid && upd_move;

   // slot sequencing
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         mask_c[c] = chan_enable_ff[c] && (chan_count_ff > CH_COUNT_BITS'(c));
      end
      period_c   = (period_ff == '0) ? COUNT_BITS'(1) : period_ff;
      pulse_c    = (pulse_ff > period_c) ? period_c : pulse_ff;
      first_c    = first_enabled(mask_c);
      load_phase = PHASE_BITS'(start_phase_ff);
      load_step  = PHASE_BITS'($signed(start_step_ff));
      load_incr  = PHASE_BITS'(step_incr_ff);

      reload_c   = req_restart || !mask_c[chan_ff] || (pos_ff >= period_c);
      chan_use   = req_restart ? first_c : (reload_c ? next_enabled(chan_ff, mask_c) : chan_ff);
      pos_use    = reload_c ? '0 : pos_ff;
      phase_use  = reload_c ? load_phase : phase_ff;
      step_use   = reload_c ? load_step : step_ff;
      active_c   = pos_use < pulse_c;

      pos_inc    = pos_use + COUNT_BITS'(1);
      slot_end   = (pos_inc >= period_c) || (pos_inc == '0);

      upd_in.phase  = phase_use;
      upd_in.chan   = chan_use;
      upd_in.pos    = pos_use;
      upd_in.active = active_c;
      upd_in.eof    = (pos_use == period_c - COUNT_BITS'(1)) &&
                      (chan_use == last_enabled(mask_c));

      if (slot_end) begin
         chan_in  = next_enabled(chan_use, mask_c);
         pos_in   = '0;
         phase_in = load_phase;
         step_in  = load_step;
      end else begin
         chan_in  = chan_use;
         pos_in   = pos_inc;
         phase_in = active_c ? phase_use + step_use : phase_use;
         step_in  = active_c ? step_use + load_incr : step_use;
      end
   end

   assign state_load   = req_take && (mask_c != '0);
   assign upd_valid_in = upd_move ? state_load : upd_valid_ff;
   assign out_valid_in = out_move ? upd_valid_ff : out_valid_ff;

   // rom addressing
   assign frac_c    = upd_ff.phase[FRAC_BITS-1:0];
   assign prod_c    = PROD_BITS'(frac_c) * PROD_BITS'(SINE_TABLE_DEPTH);
   assign idx_c     = prod_c[PROD_BITS-1:FRAC_BITS];
   assign idx_rev_c = IDX_BITS'(SINE_TABLE_DEPTH - 1) - idx_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= PERIOD_RESET;
         pulse_ff       <= PULSE_RESET;
         start_phase_ff <= PHASE_RESET;
         start_step_ff  <= STEP_RESET;
         step_incr_ff   <= INCR_RESET;
         chan_count_ff  <= COUNT_RESET;
         chan_enable_ff <= ENABLE_RESET;
         pos_ff         <= '0;
         chan_ff        <= first_enabled(ENABLE_RESET);
         phase_ff       <= PHASE_BITS'(PHASE_RESET);
         step_ff        <= PHASE_BITS'($signed(STEP_RESET));
         upd_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_PERIOD_SAMPLES: period_ff      <= csr_data[COUNT_BITS-1:0];
               CSR_PULSE_SAMPLES:  pulse_ff       <= csr_data[COUNT_BITS-1:0];
               CSR_START_PHASE:    start_phase_ff <= csr_data[CFG_BITS-1:0];
               CSR_START_STEP:     start_step_ff  <= csr_data[CFG_BITS-1:0];
               CSR_STEP_INCREMENT: step_incr_ff   <= csr_data[CFG_BITS-1:0];
               CSR_CHANNEL_COUNT:  chan_count_ff  <= csr_data[CH_COUNT_BITS-1:0];
               CSR_CHANNEL_ENABLE: chan_enable_ff <= csr_data[CHANNELS-1:0];
               default: ;
            endcase
         end
         if (state_load) begin
            pos_ff   <= pos_in;
            chan_ff  <= chan_in;
            phase_ff <= phase_in;
            step_ff  <= step_in;
         end
         upd_valid_ff <= upd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (upd_move) begin
         upd_ff <= upd_in;
      end
      if (out_move) begin
         out_ff.amp_a  <= SINE_ROM[idx_c];
         out_ff.amp_b  <= SINE_ROM[idx_rev_c];
         out_ff.quad   <= quad_type'(upd_ff.phase[PHASE_BITS-1 -: 2]);
         out_ff.chan   <= upd_ff.chan;
         out_ff.pos    <= upd_ff.pos;
         out_ff.active <= upd_ff.active;
         out_ff.eof    <= upd_ff.eof;
      end
   end

   // quadrant folding
   always_comb begin
      amp_a_s = $signed({1'b0, out_ff.amp_a});
      amp_b_s = $signed({1'b0, out_ff.amp_b});
      case (out_ff.quad)
         QUAD_RISE_POS: begin
            sin_c = amp_a_s;
            cos_c = amp_b_s;
         end
         QUAD_FALL_POS: begin
            sin_c = amp_b_s;
            cos_c = -amp_a_s;
         end
         QUAD_RISE_NEG: begin
            sin_c = -amp_a_s;
            cos_c = -amp_b_s;
         end
         QUAD_FALL_NEG: begin
            sin_c = -amp_b_s;
            cos_c = amp_a_s;
         end
         default: begin
            sin_c = '0;
            cos_c = '0;
         end
      endcase
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample_i      = out_ff.active ? cos_c : '0;
   assign rsp_sample_q      = out_ff.active ? sin_c : '0;
   assign rsp_channel       = out_ff.chan;
   assign rsp_active        = out_ff.active;
   assign rsp_slot_position = out_ff.pos;
   assign rsp_end_of_frame  = out_ff.eof;

   // restart lands on position zero of the first enabled channel
   a_restart_slot: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_restart && mask_c != '0) |=>
         (upd_ff.pos == '0 && upd_ff.chan == $past(first_c)))
      else $error("restart did not start the first enabled slot");

   // the owner of every produced word is an enabled channel
   a_owner_enabled: assert property (@(posedge clock) disable iff (reset)
      (req_take && mask_c != '0) |=>
         ((($past(mask_c)) >> upd_ff.chan) & chan_mask_type'(1)) != '0)
      else $error("word owned by a disabled channel");

   // outside the chirp the sample is zero
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_active) |-> (rsp_sample_i == '0 && rsp_sample_q == '0))
      else $error("nonzero sample outside chirp");

   // inside the chirp the vector never collapses to zero
   a_active_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_active) |-> (rsp_sample_i != '0 || rsp_sample_q != '0))
      else $error("zero sample inside chirp");

   // the input is held only while both stages are full and rsp_stall is high
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (upd_valid_ff && out_valid_ff && rsp_stall))
      else $error("input held with a free stage");

endmodule
